[design/rect_fill_copy_dma_engine_top_assert.svh]
// ----------------------------------------------------------------------------
// rect_fill_copy_dma_engine_top_assert.svh
// Assertion macros for the 2D fill/copy DMA engine. All are clocked on clk
// and are held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RECT_FILL_COPY_DMA_ENGINE_TOP_ASSERT_SVH
`define RECT_FILL_COPY_DMA_ENGINE_TOP_ASSERT_SVH

// Implication checked in the same cycle
`define RFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds at every edge
`define RFC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

[design/rfc_pkg.sv]
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types and codes for the 2D fill/copy DMA engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

  // Input opcodes
  localparam logic [2:0] OP_FILL    = 3'd0;
  localparam logic [2:0] OP_COPY    = 3'd1;
  localparam logic [2:0] OP_ADVANCE = 3'd2;
  localparam logic [2:0] OP_RETURN  = 3'd3;
  localparam logic [2:0] OP_ABORT   = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_OUT_ADDR   = 3'd0;
  localparam logic [2:0] CFG_OUT_OFFSET = 3'd1;
  localparam logic [2:0] CFG_SRC_ADDR   = 3'd2;
  localparam logic [2:0] CFG_SRC_OFFSET = 3'd3;
  localparam logic [2:0] CFG_FILL_COLOR = 3'd4;
  localparam logic [2:0] CFG_PPL        = 3'd5;
  localparam logic [2:0] CFG_LINES      = 3'd6;

  // Result word bit positions in out_tdata
  localparam int OUT_BUSY_BIT  = 48;
  localparam int OUT_DONE_BIT  = 49;
  localparam int OUT_ERROR_BIT = 50;
  localparam int OUT_IRQ_BIT   = 51;

  // Classified command kinds
  typedef enum logic [2:0] {
    CMD_FILL,
    CMD_COPY,
    CMD_ADVANCE,
    CMD_RETURN,
    CMD_ABORT,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  // Memory access codes
  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_READ  = 2'd1,
    MEM_WRITE = 2'd2
  } mem_op_t;

  // Command word held in the queue
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] read_data;
    logic        bus_error;
  } cmd_word_t;

  // Live configuration seen by the engine
  typedef struct packed {
    logic [31:0] output_address;
    logic [13:0] output_line_offset;
    logic [31:0] source_address;
    logic [13:0] source_line_offset;
    logic [15:0] fill_color;
    logic [13:0] pixels_per_line;
    logic [15:0] line_count;
  } cfg_regs_t;

  // One result word
  typedef struct packed {
    mem_op_t     mem_op;
    logic        irq;
    logic        error_flag;
    logic        done_flag;
    logic        busy;
    logic [15:0] mem_data;
    logic [31:0] mem_address;
  } res_word_t;

  // Opcode to command kind; unused codes become no-ops
  function automatic cmd_kind_t classify(input logic [2:0] op);
    cmd_kind_t k;
    case (op)
      OP_FILL:    k = CMD_FILL;
      OP_COPY:    k = CMD_COPY;
      OP_ADVANCE: k = CMD_ADVANCE;
      OP_RETURN:  k = CMD_RETURN;
      OP_ABORT:   k = CMD_ABORT;
      OP_CLEAR:   k = CMD_CLEAR;
      default:    k = CMD_NOP;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

[design/rfc_cmd_queue.sv]
// ----------------------------------------------------------------------------
// rfc_cmd_queue
// Front end: accepts input words, classifies the opcode and holds the
// command in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfc_cmd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [2:0]        in_opcode,
  input  wire logic [15:0]       in_read_data,
  input  wire logic              in_bus_error,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output rfc_pkg::cmd_word_t     q_word
);
  import rfc_pkg::*;

  cmd_word_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_word   = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, classified on the way in
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{kind: classify(in_opcode),
                           read_data: in_read_data,
                           bus_error: in_bus_error};
    end
  end

endmodule

`default_nettype wire

[design/rfc_engine.sv]
// ----------------------------------------------------------------------------
// rfc_engine
// Back end: runs the rectangle walk, one command per cycle while the result
// register is free or being taken, and drives a registered result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfc_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rfc_pkg::cfg_regs_t cfg,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire rfc_pkg::cmd_word_t q_word,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output rfc_pkg::res_word_t     res_word
);
  import rfc_pkg::*;

  logic        running_r, running_nxt;
  logic        copy_mode_r, copy_mode_nxt;
  logic        read_pending_r, read_pending_nxt;
  logic [31:0] dest_cursor_r, dest_cursor_nxt;
  logic [31:0] src_cursor_r, src_cursor_nxt;
  logic [13:0] column_r, column_nxt;
  logic [15:0] row_r, row_nxt;
  logic        done_r, done_nxt;
  logic        error_r, error_nxt;
  logic        res_valid_r, res_valid_nxt;
  res_word_t   res_word_r, res_word_nxt;

  logic        pop;
  logic [14:0] next_col;
  logic [16:0] next_row;
  logic        line_end, xfer_end;
  logic [14:0] dest_skip, src_skip;
  logic [31:0] dest_step, src_step;

  assign q_ready   = !res_valid_r || res_ready;
  assign pop       = q_valid && q_ready;
  assign res_valid = res_valid_r;
  assign res_word  = res_word_r;

  // pixel step arithmetic
  always_comb begin
    next_col  = {1'b0, column_r} + 15'd1;
    next_row  = {1'b0, row_r} + 17'd1;
    line_end  = (next_col >= {1'b0, cfg.pixels_per_line});
    xfer_end  = (next_row >= {1'b0, cfg.line_count});
    dest_skip = {1'b0, cfg.output_line_offset} + 15'd1;
    src_skip  = {1'b0, cfg.source_line_offset} + 15'd1;
    dest_step = line_end ? dest_cursor_r + {16'd0, dest_skip, 1'b0}
                         : dest_cursor_r + 32'd2;
    src_step  = line_end ? src_cursor_r + {16'd0, src_skip, 1'b0}
                         : src_cursor_r + 32'd2;
  end

  // command execution
  always_comb begin
    logic do_step;
    logic irq;
    mem_op_t     op;
    logic [31:0] addr;
    logic [15:0] data;

    running_nxt      = running_r;
    copy_mode_nxt    = copy_mode_r;
    read_pending_nxt = read_pending_r;
    dest_cursor_nxt  = dest_cursor_r;
    src_cursor_nxt   = src_cursor_r;
    column_nxt       = column_r;
    row_nxt          = row_r;
    done_nxt         = done_r;
    error_nxt        = error_r;
    do_step          = 1'b0;
    irq              = 1'b0;
    op               = MEM_NONE;
    addr             = 32'd0;
    data             = 16'd0;

    case (q_word.kind)
      CMD_FILL, CMD_COPY: begin
        if (!running_r) begin
          if (cfg.pixels_per_line == 14'd0 || cfg.line_count == 16'd0) begin
            error_nxt = 1'b1;
            irq       = 1'b1;
          end else begin
            running_nxt      = 1'b1;
            copy_mode_nxt    = (q_word.kind == CMD_COPY);
            read_pending_nxt = 1'b0;
            dest_cursor_nxt  = cfg.output_address;
            src_cursor_nxt   = cfg.source_address;
            column_nxt       = 14'd0;
            row_nxt          = 16'd0;
          end
        end
      end
      CMD_ADVANCE: begin
        if (running_r) begin
          if (!copy_mode_r) begin
            op      = MEM_WRITE;
            addr    = dest_cursor_r;
            data    = cfg.fill_color;
            do_step = 1'b1;
          end else if (!read_pending_r) begin
            op               = MEM_READ;
            addr             = src_cursor_r;
            read_pending_nxt = 1'b1;
          end
        end
      end
      CMD_RETURN: begin
        if (running_r && copy_mode_r && read_pending_r) begin
          read_pending_nxt = 1'b0;
          if (q_word.bus_error) begin
            running_nxt = 1'b0;
            error_nxt   = 1'b1;
            irq         = 1'b1;
          end else begin
            op      = MEM_WRITE;
            addr    = dest_cursor_r;
            data    = q_word.read_data;
            do_step = 1'b1;
          end
        end
      end
      CMD_ABORT: begin
        running_nxt      = 1'b0;
        read_pending_nxt = 1'b0;
      end
      CMD_CLEAR: begin
        done_nxt  = 1'b0;
        error_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    // advance cursors; the last pixel ends the transfer
    if (do_step) begin
      dest_cursor_nxt = dest_step;
      src_cursor_nxt  = src_step;
      if (line_end) begin
        column_nxt = 14'd0;
        if (xfer_end) begin
          row_nxt          = 16'd0;
          running_nxt      = 1'b0;
          read_pending_nxt = 1'b0;
          done_nxt         = 1'b1;
          irq              = 1'b1;
        end else begin
          row_nxt = next_row[15:0];
        end
      end else begin
        column_nxt = next_col[13:0];
      end
    end

    res_word_nxt = '{mem_op: op, irq: irq, error_flag: error_nxt,
                     done_flag: done_nxt, busy: running_nxt,
                     mem_data: data, mem_address: addr};
    res_valid_nxt = pop ? 1'b1 : (res_valid_r && !res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r      <= 1'b0;
      copy_mode_r    <= 1'b0;
      read_pending_r <= 1'b0;
      dest_cursor_r  <= 32'd0;
      src_cursor_r   <= 32'd0;
      column_r       <= 14'd0;
      row_r          <= 16'd0;
      done_r         <= 1'b0;
      error_r        <= 1'b0;
      res_valid_r    <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (pop) begin
        running_r      <= running_nxt;
        copy_mode_r    <= copy_mode_nxt;
        read_pending_r <= read_pending_nxt;
        dest_cursor_r  <= dest_cursor_nxt;
        src_cursor_r   <= src_cursor_nxt;
        column_r       <= column_nxt;
        row_r          <= row_nxt;
        done_r         <= done_nxt;
        error_r        <= error_nxt;
      end
    end
  end

  // result register, no reset needed
  always_ff @(posedge clk) begin
    if (pop) begin
      res_word_r <= res_word_nxt;
    end
  end

endmodule

`default_nettype wire

[design/rect_fill_copy_dma_engine_top.sv]
// ----------------------------------------------------------------------------
// rect_fill_copy_dma_engine_top
// 2D DMA engine for RGB565 rectangles: colour fill and memory copy.
// ----------------------------------------------------------------------------
// Each command word produces exactly one result word. The engine sustains one
// word per clock while out_tready does not hold back a pending result: the
// cursor update and line/transfer end test are combinational in the engine,
// with a two-entry command queue in front and a registered result stage behind.
// An accepted input word passes through the queue and then the result register
// before its result word is offered. Configuration registers are read live by
// the engine; write them only while no command is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "rect_fill_copy_dma_engine_top_assert.svh"

module rect_fill_copy_dma_engine_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [15:0] read_data, [16] bus_error, zero fill
  input  wire logic [2:0]  in_tuser,   // [2:0] opcode
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [31:0] mem_address, [47:32] mem_data,
                                       // [48] busy_res, [49] done_flag,
                                       // [50] error_flag, [51] irq, zero fill
  output logic [1:0]       out_tuser,  // [1:0] mem_op
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import rfc_pkg::*;

  cfg_regs_t cfg_r, cfg_nxt;
  logic      q_valid, q_ready;
  cmd_word_t q_word;
  res_word_t res_word;

  // register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_OUT_ADDR:   cfg_nxt.output_address     = cfg_wdata;
        CFG_OUT_OFFSET: cfg_nxt.output_line_offset = cfg_wdata[13:0];
        CFG_SRC_ADDR:   cfg_nxt.source_address     = cfg_wdata;
        CFG_SRC_OFFSET: cfg_nxt.source_line_offset = cfg_wdata[13:0];
        CFG_FILL_COLOR: cfg_nxt.fill_color         = cfg_wdata[15:0];
        CFG_PPL:        cfg_nxt.pixels_per_line    = cfg_wdata[13:0];
        CFG_LINES:      cfg_nxt.line_count         = cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end
  rfc_cmd_queue u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_opcode    (in_tuser),
    .in_read_data (in_tdata[15:0]),
    .in_bus_error (in_tdata[16]),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_word       (q_word)
  );

  // back end
  rfc_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_word    (q_word),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_word  (res_word)
  );

  // pack the result word
  assign out_tuser = res_word.mem_op;
  assign out_tdata = {4'd0, res_word.irq, res_word.error_flag, res_word.done_flag,
                      res_word.busy, res_word.mem_data, res_word.mem_address};

  // checks
  `RFC_ASSERT_IMP(a_irq_not_busy, out_tvalid && out_tdata[OUT_IRQ_BIT],
                  !out_tdata[OUT_BUSY_BIT], "irq raised while still busy")
  `RFC_ASSERT_IMP(a_irq_has_flag, out_tvalid && out_tdata[OUT_IRQ_BIT],
                  out_tdata[OUT_DONE_BIT] || out_tdata[OUT_ERROR_BIT],
                  "irq without done or error flag")
  `RFC_ASSERT_IMP(a_read_busy, out_tvalid && (out_tuser == MEM_READ),
                  out_tdata[OUT_BUSY_BIT] && (out_tdata[47:32] == 16'd0),
                  "read request outside a running copy or with data")
  `RFC_ASSERT_ALWAYS(a_no_access_zero,
                     !out_tvalid || (out_tuser != MEM_NONE) || (out_tdata[47:0] == 48'd0),
                     "idle result carries address or data")

endmodule

`default_nettype wire
